/* sv/mnsp_pkg.sv */
// shared types and constants for the markov next-shard predictor
`default_nettype none
package mnsp_pkg;

    localparam int NUM_SHARDS_DEF = 16;
    localparam int MAX_OUT        = 16;
    localparam int ID_W           = 4;
    localparam int CNT_W          = 32;
    localparam int TIME_W         = 40;
    localparam int SUM_W          = 48;
    localparam int DEN_W          = SUM_W + 1;
    localparam int KEY_W          = CNT_W;
    localparam int WIN_W          = 16;
    localparam int TOPK_W         = 5;
    localparam int SCORE_NUM      = 1000;
    localparam int WIN_MIN        = 2;
    localparam int PROD_W         = CNT_W + 10;

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_RECORD  = 2'd0,
        ACT_PREDICT = 2'd1,
        ACT_LIST    = 2'd2,
        ACT_CLEAR   = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_REC_RD,
        ST_REC_WR,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_SCAN_DIV,
        ST_PICK,
        ST_SEL_RD,
        ST_SEL_CMP,
        ST_OUT_RD,
        ST_OUT_EMIT,
        ST_EMPTY
    } t_state;

endpackage
`default_nettype wire

/* sv/mnsp_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module mnsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* sv/mnsp_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module mnsp_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [mnsp_pkg::SUM_W-1:0]  i_num,
    input  wire logic [mnsp_pkg::DEN_W-1:0]  i_den,
    output logic                             o_done,
    output logic      [mnsp_pkg::SUM_W-1:0]  o_quo
);

    localparam int SW = mnsp_pkg::SUM_W;
    localparam int DW = mnsp_pkg::DEN_W;
    localparam int CW = $clog2(SW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;

    logic [DW:0]   sh;
    logic [DW:0]   diff;
    logic          ge;

    always_comb begin
        sh   = {r_rem, r_num[SW-1]};
        diff = sh - {1'b0, r_den};
        ge   = sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DW-1:0] : sh[DW-1:0];
                r_num <= {r_num[SW-2:0], ge};
                if (32'(r_cnt) == SW - 1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule
`default_nettype wire

/* sv/markov_next_shard_predictor.sv */
// top level of the markov next-shard predictor
// Usage: an item is taken when start is high and busy is low; results come out one per
// o_strobe pulse and cannot be held off, so the receiver must take every beat. A record
// reads and then writes the shard's stats and transition count; a clear sweeps all
// NUM_SHARDS*NUM_SHARDS transition entries, the same sweep that runs after reset before the
// first item is taken. Predict and list first scan every shard, using the shared 48-step
// divider for each shard that needs it (interval score or mean interval), then pick each
// emitted item by a pass over the ranking keys and emit it. Ties in rank go to the lower
// shard id.
`default_nettype none
module markov_next_shard_predictor #(
    parameter int NUM_SHARDS = mnsp_pkg::NUM_SHARDS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   i_action,
    input  wire logic [mnsp_pkg::ID_W-1:0]    i_shard_id,
    input  wire logic [mnsp_pkg::TIME_W-1:0]  i_time_ms,
    input  wire logic [mnsp_pkg::TOPK_W-1:0]  i_top_k,
    input  wire logic                         i_cfg_we,
    input  wire logic [mnsp_pkg::WIN_W-1:0]   i_cfg_wdata,
    output logic                              o_strobe,
    output logic                              o_item_valid,
    output logic      [mnsp_pkg::ID_W-1:0]    o_item_shard,
    output logic      [mnsp_pkg::CNT_W-1:0]   o_hit_count,
    output logic      [mnsp_pkg::TIME_W-1:0]  o_mean_interval_ms,
    output logic      [mnsp_pkg::TIME_W-1:0]  o_last_seen_ms,
    output logic                              o_last_item
);

    localparam int SW    = $clog2(NUM_SHARDS);
    localparam int TAW   = $clog2(NUM_SHARDS * NUM_SHARDS);
    localparam int CNT_W = mnsp_pkg::CNT_W;
    localparam int TW    = mnsp_pkg::TIME_W;
    localparam int SUMW  = mnsp_pkg::SUM_W;
    localparam int STW   = CNT_W + TW + SUMW;
    localparam int KW    = mnsp_pkg::KEY_W + TW;

    mnsp_pkg::t_state  r_state, n_state;
    mnsp_pkg::t_action r_act;
    logic [mnsp_pkg::ID_W-1:0]   r_shard;
    logic [TW-1:0]               r_time;
    logic [mnsp_pkg::TOPK_W-1:0] r_topk;
    logic [mnsp_pkg::WIN_W-1:0]  r_win;
    logic [mnsp_pkg::ID_W-1:0]   r_prev;
    logic [1:0]                  r_fill;
    logic [SW-1:0]               r_idx;
    logic [TAW-1:0]              r_clr;
    logic [NUM_SHARDS-1:0]       r_cand;
    logic [SW:0]                 r_ncand;
    logic [mnsp_pkg::TOPK_W-1:0] r_emit;
    logic                        r_found;
    logic [SW-1:0]               r_best;
    logic [mnsp_pkg::KEY_W-1:0]  r_best_key;
    logic [TW-1:0]               r_best_mean;

    // ram ports
    logic            st_we;
    logic [SW-1:0]   st_waddr, st_raddr;
    logic [STW-1:0]  st_wdata, st_rdata;
    logic            tr_we;
    logic [TAW-1:0]  tr_waddr, tr_raddr;
    logic [CNT_W-1:0] tr_wdata, tr_rdata;
    logic            ky_we;
    logic [SW-1:0]   ky_waddr, ky_raddr;
    logic [KW-1:0]   ky_wdata, ky_rdata;

    // divider
    logic                    div_start, div_done;
    logic [SUMW-1:0]         div_num, div_quo;
    logic [mnsp_pkg::DEN_W-1:0] div_den;

    logic [CNT_W-1:0] st_count;
    logic [TW-1:0]    st_last;
    logic [SUMW-1:0]  st_sum;
    logic             shard_ok, prev_ok, idx_last, sel_last, is_pred;
    logic [TAW-1:0]   cur_taddr, rec_taddr;
    logic [CNT_W-1:0] tc;
    logic             skip, inc, need_div;
    logic [mnsp_pkg::KEY_W-1:0] ev_key;
    logic [mnsp_pkg::KEY_W-1:0] dv_key;
    logic [TW-1:0]    dv_mean;
    logic [mnsp_pkg::TOPK_W-1:0] lim;
    logic             out_last;
    logic [mnsp_pkg::PROD_W-1:0] prod;
    logic [SUMW:0]    sum_add;
    logic [SUMW-1:0]  sum_new;
    logic [CNT_W-1:0] cnt_new;
    logic             tr_inc;
    logic [KW-1:0]    ky_sel;

    assign st_count = st_rdata[STW-1 -: CNT_W];
    assign st_last  = st_rdata[SUMW +: TW];
    assign st_sum   = st_rdata[SUMW-1:0];
    assign is_pred  = (r_act == mnsp_pkg::ACT_PREDICT);
    assign shard_ok = 32'(r_shard) < NUM_SHARDS;
    assign prev_ok  = 32'(r_prev) < NUM_SHARDS;
    assign idx_last = 32'(r_idx) == NUM_SHARDS - 1;
    assign sel_last = idx_last;
    assign cur_taddr = TAW'(32'(r_shard) * NUM_SHARDS + 32'(r_idx));
    assign rec_taddr = TAW'(32'(r_prev) * NUM_SHARDS + 32'(r_shard));
    assign lim = (!is_pred || r_topk > mnsp_pkg::TOPK_W'(mnsp_pkg::MAX_OUT))
                 ? mnsp_pkg::TOPK_W'(mnsp_pkg::MAX_OUT) : r_topk;
    assign out_last = (r_emit + 1'b1 == lim) || (r_ncand == (SW+1)'(1));
    assign busy = (r_state != mnsp_pkg::ST_IDLE);

    // scan evaluation
    always_comb begin
        tc       = shard_ok ? tr_rdata : '0;
        skip     = 32'(r_idx) == 32'(r_shard);
        prod     = mnsp_pkg::PROD_W'(st_count) * mnsp_pkg::PROD_W'(mnsp_pkg::SCORE_NUM);
        if (is_pred) begin
            inc      = !skip && (tc != '0 || st_count != '0);
            need_div = !skip && tc == '0 && st_count != '0 && st_last != '0;
            ev_key   = tc;
            div_num  = SUMW'(prod);
            div_den  = mnsp_pkg::DEN_W'(st_sum) + mnsp_pkg::DEN_W'(st_count);
        end else begin
            inc      = st_count != '0;
            need_div = st_count > CNT_W'(1);
            ev_key   = st_count;
            div_num  = st_sum;
            div_den  = mnsp_pkg::DEN_W'(st_count - 1'b1);
        end
        dv_key  = is_pred ? mnsp_pkg::KEY_W'(div_quo) : st_count;
        dv_mean = is_pred ? '0
                : ((div_quo > SUMW'(mnsp_pkg::TIME_MAX)) ? mnsp_pkg::TIME_MAX : TW'(div_quo));
    end

    // record update
    always_comb begin
        sum_add = (SUMW+1)'(st_sum) + (SUMW+1)'(r_time - st_last);
        if (st_last != '0 && r_time > st_last) begin
            sum_new = sum_add[SUMW] ? mnsp_pkg::SUM_MAX : sum_add[SUMW-1:0];
        end else begin
            sum_new = st_sum;
        end
        cnt_new = (st_count == mnsp_pkg::CNT_MAX) ? st_count : st_count + 1'b1;
        tr_inc  = r_win >= mnsp_pkg::WIN_W'(mnsp_pkg::WIN_MIN) && r_fill != 2'd0
                  && r_prev != r_shard && prev_ok && shard_ok;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mnsp_pkg::ST_CLR: begin
                if (32'(r_clr) == NUM_SHARDS * NUM_SHARDS - 1) n_state = mnsp_pkg::ST_IDLE;
            end
            mnsp_pkg::ST_IDLE: begin
                if (start) begin
                    case (mnsp_pkg::t_action'(i_action))
                        mnsp_pkg::ACT_RECORD: n_state = mnsp_pkg::ST_REC_RD;
                        mnsp_pkg::ACT_CLEAR:  n_state = mnsp_pkg::ST_CLR;
                        default:              n_state = mnsp_pkg::ST_SCAN_RD;
                    endcase
                end
            end
            mnsp_pkg::ST_REC_RD:  n_state = mnsp_pkg::ST_REC_WR;
            mnsp_pkg::ST_REC_WR:  n_state = mnsp_pkg::ST_IDLE;
            mnsp_pkg::ST_SCAN_RD: n_state = mnsp_pkg::ST_SCAN_EV;
            mnsp_pkg::ST_SCAN_EV: begin
                if (need_div)      n_state = mnsp_pkg::ST_SCAN_DIV;
                else if (idx_last) n_state = mnsp_pkg::ST_PICK;
                else               n_state = mnsp_pkg::ST_SCAN_RD;
            end
            mnsp_pkg::ST_SCAN_DIV: begin
                if (div_done) n_state = idx_last ? mnsp_pkg::ST_PICK : mnsp_pkg::ST_SCAN_RD;
            end
            mnsp_pkg::ST_PICK: begin
                n_state = (r_ncand == '0 || lim == '0) ? mnsp_pkg::ST_EMPTY
                                                       : mnsp_pkg::ST_SEL_RD;
            end
            mnsp_pkg::ST_SEL_RD:  n_state = mnsp_pkg::ST_SEL_CMP;
            mnsp_pkg::ST_SEL_CMP: n_state = sel_last ? mnsp_pkg::ST_OUT_RD
                                                     : mnsp_pkg::ST_SEL_RD;
            mnsp_pkg::ST_OUT_RD:  n_state = mnsp_pkg::ST_OUT_EMIT;
            mnsp_pkg::ST_OUT_EMIT: n_state = out_last ? mnsp_pkg::ST_IDLE
                                                      : mnsp_pkg::ST_SEL_RD;
            mnsp_pkg::ST_EMPTY:   n_state = mnsp_pkg::ST_IDLE;
            default:              n_state = mnsp_pkg::ST_IDLE;
        endcase
    end

    // ram and divider controls
    always_comb begin
        st_we     = 1'b0;
        st_waddr  = SW'(r_shard);
        st_wdata  = {cnt_new, r_time, sum_new};
        st_raddr  = r_idx;
        tr_we     = 1'b0;
        tr_waddr  = rec_taddr;
        tr_wdata  = (tr_rdata == mnsp_pkg::CNT_MAX) ? tr_rdata : tr_rdata + 1'b1;
        tr_raddr  = cur_taddr;
        ky_we     = 1'b0;
        ky_waddr  = r_idx;
        ky_wdata  = {ev_key, TW'(0)};
        ky_raddr  = r_idx;
        div_start = 1'b0;
        case (r_state)
            mnsp_pkg::ST_CLR: begin
                st_we    = 32'(r_clr) < NUM_SHARDS;
                st_waddr = SW'(r_clr);
                st_wdata = '0;
                tr_we    = 1'b1;
                tr_waddr = r_clr;
                tr_wdata = '0;
            end
            mnsp_pkg::ST_REC_RD: begin
                st_raddr = SW'(r_shard);
                tr_raddr = rec_taddr;
            end
            mnsp_pkg::ST_REC_WR: begin
                st_we    = shard_ok;
                tr_we    = tr_inc;
                st_raddr = SW'(r_shard);
                tr_raddr = rec_taddr;
            end
            mnsp_pkg::ST_SCAN_EV: begin
                div_start = need_div;
                ky_we     = inc && !need_div;
            end
            mnsp_pkg::ST_SCAN_DIV: begin
                ky_we    = div_done;
                ky_wdata = {dv_key, dv_mean};
            end
            mnsp_pkg::ST_OUT_RD, mnsp_pkg::ST_OUT_EMIT: begin
                st_raddr = r_best;
            end
            default: begin
            end
        endcase
    end

    assign ky_sel = ky_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mnsp_pkg::ST_CLR;
            r_clr        <= '0;
            r_win        <= mnsp_pkg::WIN_W'(16);
            r_prev       <= '0;
            r_fill       <= '0;
            r_idx        <= '0;
            r_cand       <= '0;
            r_ncand      <= '0;
            r_emit       <= '0;
            r_found      <= 1'b0;
            o_strobe     <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= 1'b0;
            if (i_cfg_we) r_win <= i_cfg_wdata;
            case (r_state)
                mnsp_pkg::ST_CLR: begin
                    r_clr  <= r_clr + 1'b1;
                    r_prev <= '0;
                    r_fill <= '0;
                end
                mnsp_pkg::ST_IDLE: begin
                    r_act   <= mnsp_pkg::t_action'(i_action);
                    r_shard <= i_shard_id;
                    r_time  <= i_time_ms;
                    r_topk  <= i_top_k;
                    r_idx   <= '0;
                    r_clr   <= '0;
                    r_cand  <= '0;
                    r_ncand <= '0;
                    r_emit  <= '0;
                end
                mnsp_pkg::ST_REC_WR: begin
                    if (shard_ok) begin
                        r_prev <= r_shard;
                        if (r_fill != 2'd2) r_fill <= r_fill + 1'b1;
                    end
                end
                mnsp_pkg::ST_SCAN_EV: begin
                    if (inc) begin
                        r_cand[r_idx] <= 1'b1;
                        r_ncand       <= r_ncand + 1'b1;
                    end
                    if (!need_div && !idx_last) r_idx <= r_idx + 1'b1;
                end
                mnsp_pkg::ST_SCAN_DIV: begin
                    if (div_done && !idx_last) r_idx <= r_idx + 1'b1;
                end
                mnsp_pkg::ST_PICK: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                end
                mnsp_pkg::ST_SEL_CMP: begin
                    // strict compare keeps the lower id on ties
                    if (r_cand[r_idx] && (!r_found || ky_sel[KW-1 -: mnsp_pkg::KEY_W] > r_best_key))
                    begin
                        r_found     <= 1'b1;
                        r_best      <= r_idx;
                        r_best_key  <= ky_sel[KW-1 -: mnsp_pkg::KEY_W];
                        r_best_mean <= ky_sel[TW-1:0];
                    end
                    if (!sel_last) r_idx <= r_idx + 1'b1;
                end
                mnsp_pkg::ST_OUT_EMIT: begin
                    o_strobe           <= 1'b1;
                    o_item_valid       <= 1'b1;
                    o_item_shard       <= mnsp_pkg::ID_W'(r_best);
                    o_hit_count        <= is_pred ? '0 : st_count;
                    o_mean_interval_ms <= r_best_mean;
                    o_last_seen_ms     <= is_pred ? '0 : st_last;
                    o_last_item        <= out_last;
                    r_cand[r_best]     <= 1'b0;
                    r_ncand            <= r_ncand - 1'b1;
                    r_emit             <= r_emit + 1'b1;
                    r_idx              <= '0;
                    r_found            <= 1'b0;
                end
                mnsp_pkg::ST_EMPTY: begin
                    o_strobe           <= 1'b1;
                    o_item_valid       <= 1'b0;
                    o_item_shard       <= '0;
                    o_hit_count        <= '0;
                    o_mean_interval_ms <= '0;
                    o_last_seen_ms     <= '0;
                    o_last_item        <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    mnsp_ram #(.WIDTH(STW), .DEPTH(NUM_SHARDS)) u_stats (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(st_wdata),
        .i_raddr(st_raddr),
        .o_rdata(st_rdata)
    );

    mnsp_ram #(.WIDTH(CNT_W), .DEPTH(NUM_SHARDS * NUM_SHARDS)) u_trans (
        .i_clk  (i_clk),
        .i_we   (tr_we),
        .i_waddr(tr_waddr),
        .i_wdata(tr_wdata),
        .i_raddr(tr_raddr),
        .o_rdata(tr_rdata)
    );

    mnsp_ram #(.WIDTH(KW), .DEPTH(NUM_SHARDS)) u_keys (
        .i_clk  (i_clk),
        .i_we   (ky_we),
        .i_waddr(ky_waddr),
        .i_wdata(ky_wdata),
        .i_raddr(ky_raddr),
        .o_rdata(ky_rdata)
    );

    mnsp_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

endmodule
`default_nettype wire
